>>> rtl/core/bcpg_pkg.sv
package bcpg_pkg;

    localparam int COORD_W       = 16;
    localparam int IDX_W         = 6;
    localparam int STEPS_DEFAULT = 32;
    localparam int PROD_W        = COORD_W + IDX_W + 2;

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] first_ctrl_x;
        logic signed [COORD_W-1:0] first_ctrl_y;
        logic signed [COORD_W-1:0] second_ctrl_x;
        logic signed [COORD_W-1:0] second_ctrl_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
    } in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic [IDX_W-1:0]          step_index;
        logic                      last;
    } out_t;

    // one parameter point handed from the sequencer to the evaluator
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
        logic             last;
    } issue_t;

    // a + floor(((b - a) * i) / 2^sh); result lies between a and b when i <= 2^sh
    function automatic logic signed [COORD_W-1:0] lerp(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b,
        input logic [IDX_W-1:0]          i,
        input int                        sh
    );
        logic signed [COORD_W:0]   d;
        logic signed [IDX_W:0]     m;
        logic signed [PROD_W-1:0]  p;
        d = $signed({b[COORD_W-1], b}) - $signed({a[COORD_W-1], a});
        m = $signed({1'b0, i});
        p = PROD_W'(d) * PROD_W'(m);
        p = p >>> sh;
        return a + p[COORD_W-1:0];
    endfunction

endpackage

>>> rtl/core/bcpg_eval.sv
module bcpg_eval
    import bcpg_pkg::*;
#(
    parameter int STEPS = STEPS_DEFAULT
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  in_t    pts,
    input  issue_t issue,
    output logic   adv,
    output logic   out_valid,
    input  logic   out_ready,
    output out_t   out_data
);

    localparam int SH = $clog2(STEPS + 1) - 1;

    logic                      v1_reg, v2_reg, v3_reg;
    logic [IDX_W-1:0]          idx1_reg, idx2_reg;
    logic                      last1_reg, last2_reg;
    logic signed [COORD_W-1:0] qx_reg [3];
    logic signed [COORD_W-1:0] qy_reg [3];
    logic signed [COORD_W-1:0] rx_reg [2];
    logic signed [COORD_W-1:0] ry_reg [2];
    out_t                      out_reg;

    logic signed [COORD_W-1:0] qx_next [3];
    logic signed [COORD_W-1:0] qy_next [3];
    logic signed [COORD_W-1:0] rx_next [2];
    logic signed [COORD_W-1:0] ry_next [2];
    out_t                      out_next;

    // whole pipe moves together; frozen while the result waits
    assign adv = !v3_reg || out_ready;

    always_comb
    begin
        qx_next[0] = lerp(pts.start_x,       pts.first_ctrl_x,  issue.idx, SH);
        qx_next[1] = lerp(pts.first_ctrl_x,  pts.second_ctrl_x, issue.idx, SH);
        qx_next[2] = lerp(pts.second_ctrl_x, pts.end_x,         issue.idx, SH);
        qy_next[0] = lerp(pts.start_y,       pts.first_ctrl_y,  issue.idx, SH);
        qy_next[1] = lerp(pts.first_ctrl_y,  pts.second_ctrl_y, issue.idx, SH);
        qy_next[2] = lerp(pts.second_ctrl_y, pts.end_y,         issue.idx, SH);
        rx_next[0] = lerp(qx_reg[0], qx_reg[1], idx1_reg, SH);
        rx_next[1] = lerp(qx_reg[1], qx_reg[2], idx1_reg, SH);
        ry_next[0] = lerp(qy_reg[0], qy_reg[1], idx1_reg, SH);
        ry_next[1] = lerp(qy_reg[1], qy_reg[2], idx1_reg, SH);
        out_next.point_x    = lerp(rx_reg[0], rx_reg[1], idx2_reg, SH);
        out_next.point_y    = lerp(ry_reg[0], ry_reg[1], idx2_reg, SH);
        out_next.step_index = idx2_reg;
        out_next.last       = last2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= issue.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            qx_reg    <= qx_next;
            qy_reg    <= qy_next;
            idx1_reg  <= issue.idx;
            last1_reg <= issue.last;
            rx_reg    <= rx_next;
            ry_reg    <= ry_next;
            idx2_reg  <= idx1_reg;
            last2_reg <= last1_reg;
            out_reg   <= out_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = out_reg;

endmodule

>>> rtl/core/cubic_bezier_point_generator.sv
// Channel  Dir  Handshake               Payload
// in       in   in_valid / in_ready     in_data  (in_t: four control points)
// out      out  out_valid / out_ready   out_data (out_t: point, index, last)
//
// Each request yields STEPS points, one per cycle unless out stalls; the
// point sequencer feeds the evaluator one index a cycle and takes the next
// request as it issues the last index. A point passes one registered stage
// per interpolation level. Reset clears the sequencer and all valid bits.
// A stall on out freezes the whole pipe and a busy sequencer in place.
module cubic_bezier_point_generator
    import bcpg_pkg::*;
#(
    parameter int STEPS = STEPS_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STEPS - 1);

    logic             busy_reg, busy_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    in_t              pts_reg;
    logic             adv;
    logic             at_last;
    logic             in_take;
    issue_t           issue;

    assign at_last  = cnt_reg == LAST_IDX;
    assign in_ready = !busy_reg || (adv && at_last);
    assign in_take  = in_valid && in_ready;

    always_comb
    begin
        issue.valid = busy_reg;
        issue.idx   = cnt_reg;
        issue.last  = at_last;
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (in_take)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg && adv)
        begin
            busy_next = !at_last;
            cnt_next  = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            pts_reg <= in_data;
        end
    end

    bcpg_eval #(
        .STEPS (STEPS)
    ) u_eval (
        .clk       (clk),
        .rst_n     (rst_n),
        .pts       (pts_reg),
        .issue     (issue),
        .adv       (adv),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

>>> rtl/core/bcpg_chk.sv
module bcpg_chk
    import bcpg_pkg::*;
#(
    parameter int STEPS = STEPS_DEFAULT
)
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input in_t  in_data,
    input logic out_valid,
    input logic out_ready,
    input out_t out_data
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STEPS - 1);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.last == (out_data.step_index == LAST_IDX)))
        else $error("last flag does not match final index");

    // two requests are never taken back to back
    a_no_double_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("two requests taken on consecutive cycles");

    // points of one request follow each other with no gap
    a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.last
        |=> out_valid && (out_data.step_index == IDX_W'($past(out_data.step_index) + 1'b1)))
        else $error("point index did not advance by one");

    // waiting request holds still
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_data))
        else $error("request changed while waiting");

endmodule

bind cubic_bezier_point_generator bcpg_chk #(
    .STEPS (STEPS)
) u_bcpg_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

>>> dv/bezier_point_checker.sv
module bezier_point_checker
    import bcpg_pkg::*;
#(
    parameter int STEPS = STEPS_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic in_ready,
    input  in_t  in_data,
    input  logic out_valid,
    input  logic out_ready,
    input  out_t out_data,
    output int   mismatches,
    output int   points_due,
    output int   points_checked,
    output int   requests_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEP_SHIFT = $clog2(STEPS + 1) - 1;

    out_t curve_points_q[$];

    // a + floor((b - a) * i / 2^STEP_SHIFT)
    function automatic logic signed [COORD_W-1:0] blend_toward(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b,
        input int                        i
    );
        int span;
        span = (int'(b) - int'(a)) * i;
        return COORD_W'(int'(a) + (span >>> STEP_SHIFT));
    endfunction

    function automatic logic signed [COORD_W-1:0] bezier_coord(
        input logic signed [COORD_W-1:0] p0,
        input logic signed [COORD_W-1:0] p1,
        input logic signed [COORD_W-1:0] p2,
        input logic signed [COORD_W-1:0] p3,
        input int                        i
    );
        logic signed [COORD_W-1:0] q0;
        logic signed [COORD_W-1:0] q1;
        logic signed [COORD_W-1:0] q2;
        logic signed [COORD_W-1:0] r0;
        logic signed [COORD_W-1:0] r1;
        q0 = blend_toward(p0, p1, i);
        q1 = blend_toward(p1, p2, i);
        q2 = blend_toward(p2, p3, i);
        r0 = blend_toward(q0, q1, i);
        r1 = blend_toward(q1, q2, i);
        return blend_toward(r0, r1, i);
    endfunction

    task automatic queue_curve(input in_t req);
        out_t pt;
        for (int k = 0; k < STEPS; k++)
        begin
            pt.point_x    = bezier_coord(req.start_x, req.first_ctrl_x,
                                         req.second_ctrl_x, req.end_x, k);
            pt.point_y    = bezier_coord(req.start_y, req.first_ctrl_y,
                                         req.second_ctrl_y, req.end_y, k);
            pt.step_index = IDX_W'(k);
            pt.last       = (k == STEPS - 1);
            curve_points_q.push_back(pt);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        out_t want;
        logic bad;
        if (!rst_n)
        begin
            curve_points_q.delete();
            points_due = 0;
        end
        else
        begin
            // check output first so a point can never match a request taken this edge
            if (out_valid && out_ready)
            begin
                if (curve_points_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected point: x=%0d y=%0d idx=%0d last=%0b",
                                 out_data.point_x, out_data.point_y,
                                 out_data.step_index, out_data.last);
                    mismatches++;
                end
                else
                begin
                    want = curve_points_q.pop_front();
                    points_checked++;
                    bad = (out_data.point_x !== want.point_x)
                       || (out_data.point_y !== want.point_y)
                       || (out_data.step_index !== want.step_index)
                       || (out_data.last !== want.last);
                    if (bad)
                    begin
                        if (mismatches < 10)
                            $display({"point mismatch: expected x=%0d y=%0d idx=%0d last=%0b,",
                                      " got x=%0d y=%0d idx=%0d last=%0b"},
                                     want.point_x, want.point_y, want.step_index,
                                     want.last, out_data.point_x, out_data.point_y,
                                     out_data.step_index, out_data.last);
                        mismatches++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                requests_seen++;
                queue_curve(in_data);
            end
            points_due = curve_points_q.size();
        end
    end

endmodule

>>> dv/cubic_bezier_point_generator_tb.sv
module cubic_bezier_point_generator_tb
    import bcpg_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEPS           = STEPS_DEFAULT;
    localparam int RANDOM_REQUESTS = 400;
    localparam int HOLD_CYCLES     = 300;
    localparam int LIMIT_NS        = 5_000_000;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_ready;
    in_t  in_data   = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_t out_data;

    int mismatches;
    int points_due;
    int points_checked;
    int requests_seen;

    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;
    bit hold_pending      = 1'b0;
    int hold_cycles_done  = 0;
    int directed_count    = 0;

    cubic_bezier_point_generator #(
        .STEPS (STEPS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    bezier_point_checker #(
        .STEPS (STEPS)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_data       (out_data),
        .mismatches     (mismatches),
        .points_due     (points_due),
        .points_checked (points_checked),
        .requests_seen  (requests_seen)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic in_t make_request(input int x0, input int y0, input int x1,
                                         input int y1, input int x2, input int y2,
                                         input int x3, input int y3);
        in_t r;
        r.start_x       = COORD_W'(x0);
        r.start_y       = COORD_W'(y0);
        r.first_ctrl_x  = COORD_W'(x1);
        r.first_ctrl_y  = COORD_W'(y1);
        r.second_ctrl_x = COORD_W'(x2);
        r.second_ctrl_y = COORD_W'(y2);
        r.end_x         = COORD_W'(x3);
        r.end_y         = COORD_W'(y3);
        return r;
    endfunction

    // extremes, tiny values, a neighbor of the previous point, or anything
    function automatic logic [COORD_W-1:0] pick_coord(input logic [COORD_W-1:0] near);
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return COORD_W'(int'($urandom_range(0, 64)) - 32);
            3: return COORD_W'(int'(near) + int'($urandom_range(0, 511)) - 256);
            default: return COORD_W'($urandom);
        endcase
    endfunction

    function automatic in_t random_request();
        in_t r;
        r.start_x       = pick_coord(COORD_W'($urandom));
        r.start_y       = pick_coord(COORD_W'($urandom));
        r.first_ctrl_x  = pick_coord(r.start_x);
        r.first_ctrl_y  = pick_coord(r.start_y);
        r.second_ctrl_x = pick_coord(r.first_ctrl_x);
        r.second_ctrl_y = pick_coord(r.first_ctrl_y);
        r.end_x         = pick_coord(r.second_ctrl_x);
        r.end_y         = pick_coord(r.second_ctrl_y);
        return r;
    endfunction

    task automatic send_request(input in_t req);
        bit accepted;
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do
        begin
            @(negedge clk);
            accepted = in_ready;
            @(posedge clk);
        end
        while (!accepted);
    endtask

    task automatic send_directed(input in_t req);
        send_request(req);
        directed_count++;
    endtask

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES)
                begin
                    @(posedge clk);
                    hold_cycles_done++;
                end
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
                @(posedge clk);
            end
        end
    end

    initial
    begin
        #(LIMIT_NS);
        $display("timeout with %0d points outstanding", points_due);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_directed(make_request(0, 0, 0, 0, 0, 0, 0, 0));
        send_directed(make_request(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
        send_directed(make_request(-32768, -32768, -32768, -32768,
                                   -32768, -32768, -32768, -32768));
        send_directed(make_request(-32768, 32767, 32767, -32768,
                                   -32768, 32767, 32767, -32768));
        send_directed(make_request(32767, -32768, -32768, 32767,
                                   -32768, 32767, 32767, -32768));
        send_directed(make_request(0, 0, 32767, -32768, -32768, 32767, 0, 0));
        send_directed(make_request(32767, -32768, 0, 0, 0, 0, -32768, 32767));
        send_directed(make_request(5, -5, -3, 3, 1, -1, -7, 7));
        send_directed(make_request(-1, 0, 0, -1, -1, 0, 0, -1));
        send_directed(make_request(0, 0, 100, 100, 200, 200, 300, 300));
        send_directed(make_request(1, -1, 2, -2, 3, -3, 4, -4));
        send_directed(make_request(-32768, -32768, 0, 0, 0, 0, 32767, 32767));
        send_directed(make_request(16, -16, -32768, 32767, 32767, -32768, 16, -16));
        send_directed(make_request(32767, 0, 32766, 1, -32767, -1, -32768, 0));
        for (int b = 0; b < COORD_W; b += 3)
            send_directed(make_request(1 << b, ~(1 << b), ~(1 << b), 1 << b,
                                       1 << b, ~(1 << b), ~(1 << b), 1 << b));

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    sender_idle_pct   = 21;
                    receiver_idle_pct = 54;
                end
                1:
                begin
                    sender_idle_pct   = 54;
                    receiver_idle_pct = 21;
                end
                default:
                begin
                    sender_idle_pct   = 0;
                    receiver_idle_pct = 0;
                    // long output stall while requests keep coming
                    hold_pending      = 1'b1;
                end
            endcase
            for (int n = 0; n < RANDOM_REQUESTS / 3 + 1; n++)
                send_request(random_request());
        end
        in_valid <= 1'b0;

        do
            @(negedge clk);
        while (points_due != 0);
        repeat (8) @(posedge clk);

        $display("covered %0d curve requests (%0d directed), %0d points checked",
                 requests_seen, directed_count, points_checked);
        $display("output held off for %0d cycles with input pressure, %0d mismatches",
                 hold_cycles_done, mismatches);
        if (mismatches == 0 && points_due == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/bcpg_pkg.sv
rtl/core/bcpg_eval.sv
rtl/core/cubic_bezier_point_generator.sv
rtl/core/bcpg_chk.sv
dv/bezier_point_checker.sv
dv/cubic_bezier_point_generator_tb.sv
